### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Command and status codes and the control/status bundles shared between the
// list controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch request fields and check them
        logic idx_ins;    // idx <= count
        logic idx_rm;     // idx <= pos - 1
        logic rd_shift;   // read neighbour of idx
        logic wr_shift;   // write read data to idx and step idx
        logic fin;        // insert value / update count
        logic rd_fetch;   // read entry at pos - 1
        logic cap_read;   // capture read data as result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_ins;
        logic is_rm;
        logic ok;
        logic more;       // entries still to move
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with insert, read and remove at a
// 1-based position.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on o_status, o_read_value, o_count and o_empty_res for the one
// cycle that o_strobe is high, and must be taken then, as the receiver cannot
// stall. Entries sit in a single-port-read RAM, so moving the list takes a
// read, a write and a loop check per moved entry. busy falls the cycle after
// the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_command,
    input  wire logic [6:0]         i_position,
    input  wire logic signed [31:0] i_value,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value,
    output logic [6:0]              o_count,
    output logic                    o_empty_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ple_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_empty_res  (o_empty_res)
    );

endmodule

`default_nettype wire

### rtl/core/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// List datapath: entry store, count, move index, request checks and result
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_dp
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    input  wire logic [1:0]         i_command,
    input  wire logic [6:0]         i_position,
    input  wire logic signed [31:0] i_value,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value,
    output logic [6:0]              o_count,
    output logic                    o_empty_res
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_idx, n_idx;
    logic [1:0]      r_cmd;
    logic [CMPW-1:0] r_pos;
    logic [31:0]     r_val;
    logic [1:0]      r_status;
    logic [31:0]     r_rd_val;

    logic [CMPW-1:0] pos_x, cnt_x, idx_x, pm1;
    logic            ins_pos_ok, acc_ok, full;
    logic [1:0]      n_status;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata, ram_rdata;
    logic [CW-1:0]   idx_nb;

    // request check against the current count
    assign pos_x      = {{(CMPW-7){1'b0}}, i_position};
    assign cnt_x      = {{(CMPW-CW){1'b0}}, r_cnt};
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
    assign acc_ok     = (pos_x != '0) && (pos_x <= cnt_x);
    assign full       = (cnt_x == CMPW'(CAPACITY));

    always_comb begin
        case (i_command)
            CMD_INSERT: n_status = !ins_pos_ok ? ST_ERR : (full ? ST_FULL : ST_OK);
            CMD_READ,
            CMD_REMOVE: n_status = acc_ok ? ST_OK : ST_ERR;
            default:    n_status = ST_ERR;
        endcase
    end

    assign idx_x = {{(CMPW-CW){1'b0}}, r_idx};
    assign pm1   = r_pos - CMPW'(1);

    assign o_sts.is_ins = (r_cmd == CMD_INSERT);
    assign o_sts.is_rm  = (r_cmd == CMD_REMOVE);
    assign o_sts.ok     = (r_status == ST_OK);
    assign o_sts.more   = o_sts.is_ins ? (idx_x >= r_pos) : (idx_x + CMPW'(1) < cnt_x);

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_ins) begin
            n_idx = r_cnt;
        end else if (i_cmd.idx_rm) begin
            n_idx = pm1[CW-1:0];
        end else if (i_cmd.wr_shift) begin
            n_idx = o_sts.is_ins ? r_idx - CW'(1) : r_idx + CW'(1);
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.fin) begin
            n_cnt = o_sts.is_ins ? r_cnt + CW'(1) : r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_pos    <= pos_x;
            r_val    <= i_value;
            r_status <= n_status;
            r_rd_val <= '0;
        end else if (i_cmd.cap_read) begin
            r_rd_val <= ram_rdata;
        end
    end

    // entry store
    assign idx_nb    = o_sts.is_ins ? r_idx - CW'(1) : r_idx + CW'(1);
    assign ram_we    = i_cmd.wr_shift || (i_cmd.fin && o_sts.is_ins);
    assign ram_waddr = i_cmd.fin ? pm1[AW-1:0] : r_idx[AW-1:0];
    assign ram_wdata = i_cmd.fin ? r_val : ram_rdata;
    assign ram_re    = i_cmd.rd_shift || i_cmd.rd_fetch;
    assign ram_raddr = i_cmd.rd_fetch ? pm1[AW-1:0] : idx_nb[AW-1:0];

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status     = r_status;
    assign o_read_value = r_rd_val;
    assign o_empty_res  = (r_cnt == '0);

    generate
        if (CW >= 7) begin : g_cnt_trunc
            assign o_count = r_cnt[6:0];
        end else begin : g_cnt_ext
            assign o_count = {{(7-CW){1'b0}}, r_cnt};
        end
    endgenerate

endmodule

`default_nettype wire

### rtl/core/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the list engine: dispatches a request, steps the entry moves
// one read/write pair at a time and issues the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    output logic         o_strobe,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DISP    = 9'b000000010,
        S_LOOP    = 9'b000000100,
        S_SH_RD   = 9'b000001000,
        S_SH_WR   = 9'b000010000,
        S_FIN     = 9'b000100000,
        S_FETCH   = 9'b001000000,
        S_FETCH_W = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.ok) begin
                    n_state = S_DONE;
                end else if (i_sts.is_ins) begin
                    o_cmd.idx_ins = 1'b1;
                    n_state       = S_LOOP;
                end else if (i_sts.is_rm) begin
                    o_cmd.idx_rm = 1'b1;
                    n_state      = S_LOOP;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_LOOP: begin
                n_state = i_sts.more ? S_SH_RD : S_FIN;
            end
            S_SH_RD: begin
                o_cmd.rd_shift = 1'b1;
                n_state        = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_LOOP;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_FETCH: begin
                o_cmd.rd_fetch = 1'b1;
                n_state        = S_FETCH_W;
            end
            S_FETCH_W: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule

`default_nettype wire
